[hdl/bve_pkg.sv]
// Shared types and constants of the bit vector engine.
package bve_pkg;

   localparam int CAPACITY_DEF = 4096;
   localparam int WORD_BITS    = 64;
   localparam int KIND_W       = 4;
   localparam int POS_W        = 13;
   localparam int CNT_W        = 13;
   localparam int RSP_W        = 32;
   localparam int REQ_W        = 32;

   typedef enum logic [KIND_W-1:0] {
      K_SET      = 4'd0,
      K_CLEAR    = 4'd1,
      K_FLIP     = 4'd2,
      K_TEST     = 4'd3,
      K_SETALL   = 4'd4,
      K_CLEARALL = 4'd5,
      K_INVERT   = 4'd6,
      K_COUNT    = 4'd7,
      K_ANY      = 4'd8,
      K_NEXT     = 4'd9,
      K_PREV     = 4'd10,
      K_SHL      = 4'd11,
      K_SHR      = 4'd12
   } kind_type;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_TRIM  = 2'd1,
      MODE_ITEM  = 2'd2
   } mode_type;

   typedef struct packed {
      logic     load;
      logic     issue;
      logic     finish;
      mode_type mode;
   } ctl_cmd_type;

   typedef struct packed {
      logic direct;
      logic single;
      logic desc;
   } dp_stat_type;

endpackage

[hdl/bve_datapath.sv]
// Word memory, sweep pipeline, accumulators and result registers.
module bve_datapath #(
   parameter int CAPACITY = bve_pkg::CAPACITY_DEF,
   parameter int AW       = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [bve_pkg::CNT_W-1:0] csr_wdata,
   input  logic [bve_pkg::KIND_W-1:0] item_kind,
   input  logic [bve_pkg::POS_W-1:0] item_position,
   input  logic [bve_pkg::POS_W-1:0] item_amount,
   input  bve_pkg::ctl_cmd_type     cmd,
   input  logic [AW-1:0]            cmd_idx,
   output bve_pkg::dp_stat_type     stat,
   output logic [AW-1:0]            stat_word,
   output logic                     out_bit_value,
   output logic [bve_pkg::POS_W-1:0] out_found_index,
   output logic [bve_pkg::POS_W-1:0] out_population,
   output logic                     out_any_set,
   output logic                     out_error
);
   import bve_pkg::*;

   localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int LW     = $clog2(CAPACITY + 1);
   localparam int XW     = (LW > POS_W) ? LW : POS_W;
   localparam int MW     = ((AW + 6) > XW) ? (AW + 6) : XW;
   localparam int SW     = ((AW > 7) ? AW : 7) + 2;
   localparam int FW     = AW + 6;

   function automatic logic [63:0] word_mask(input logic [AW-1:0] idx, input logic [XW-1:0] n);
      logic [MW-1:0] lo;
      logic [MW-1:0] nn;
      logic [MW-1:0] d;
      lo = MW'(idx) << 6;
      nn = MW'(n);
      d  = nn - lo;
      if (lo >= nn) return 64'd0;
      else if (d >= MW'(64)) return ~64'd0;
      else return (64'd1 << d[5:0]) - 64'd1;
   endfunction

   function automatic logic [6:0] pop64(input logic [63:0] x);
      logic [6:0] c;
      c = 7'd0;
      for (int i = 0; i < 64; i++) c = c + 7'(x[i]);
      return c;
   endfunction

   function automatic logic [5:0] low_index(input logic [63:0] x);
      logic [63:0] v;
      logic [5:0]  k;
      v = x;
      k = 6'd0;
      for (int s = 32; s >= 1; s = s >> 1) begin
         if ((v & ((64'd1 << s) - 64'd1)) == 64'd0) begin
            k = k + 6'(s);
            v = v >> s;
         end
      end
      return k;
   endfunction

   function automatic logic [5:0] high_index(input logic [63:0] x);
      logic [63:0] v;
      logic [5:0]  k;
      v = x;
      k = 6'd0;
      for (int s = 32; s >= 1; s = s >> 1) begin
         if ((v >> s) != 64'd0) begin
            k = k + 6'(s);
            v = v >> s;
         end
      end
      return k;
   endfunction

   logic [63:0] mem [NWORDS];

   logic [CNT_W-1:0]  bit_count_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  amt_ff;

   logic [63:0]   rd_a_ff, rd_b_ff;
   logic          a_ok_ff, b_ok_ff, s1_valid_ff;
   logic [AW-1:0] s1_idx_ff;

   logic [LW-1:0] pop_ff;
   logic          any_ff, hit_ff, bitv_ff;
   logic [FW-1:0] found_ff;

   logic          bit_value_ff, any_out_ff, err_out_ff;
   logic [POS_W-1:0] found_out_ff, pop_out_ff;

   kind_type    kind_e;
   logic [XW-1:0] n_x, bc_x, pos_x, prev_pos, sel_pos;
   logic        out_rng, is_single, is_next, is_prev, is_search;
   logic [5:0]  off;
   logic [6:0]  ws;
   logic [5:0]  bs;
   logic [SW-1:0] src_a, src_b;
   logic        ok_a, ok_b;
   logic [63:0] a, b, m, bitm, wdata, w_next, w_prev;
   logic        wr_en;
   logic [XW-1:0] found_res;

   always_comb begin
      kind_e    = kind_type'(kind_ff);
      bc_x      = XW'(bit_count_ff);
      n_x       = (bc_x > XW'(CAPACITY)) ? XW'(CAPACITY) : bc_x;
      pos_x     = XW'(pos_ff);
      out_rng   = pos_x >= n_x;
      prev_pos  = out_rng ? (n_x - XW'(1)) : pos_x;
      is_single = kind_ff <= K_TEST;
      is_next   = kind_e == K_NEXT;
      is_prev   = kind_e == K_PREV;
      is_search = is_next || is_prev;
      sel_pos   = is_prev ? prev_pos : pos_x;
      stat_word = sel_pos[AW+5:6];
      off       = sel_pos[5:0];
      stat.single = is_single;
      stat.desc   = kind_e == K_SHL;
      stat.direct = (is_single && out_rng) || (kind_ff > K_SHR) ||
                    (is_next && out_rng) || (is_prev && (n_x == XW'(0)));
      ws = amt_ff[12:6];
      bs = amt_ff[5:0];
   end

   // read addressing: shifts fetch the two source words of one target word
   always_comb begin
      src_a = SW'(cmd_idx);
      src_b = SW'(cmd_idx);
      ok_a  = 1'b1;
      ok_b  = 1'b0;
      if (cmd.mode == MODE_ITEM && kind_e == K_SHR) begin
         src_a = SW'(cmd_idx) + SW'(ws);
         src_b = src_a + SW'(1);
         ok_a  = src_a < SW'(NWORDS);
         ok_b  = src_b < SW'(NWORDS);
      end else if (cmd.mode == MODE_ITEM && kind_e == K_SHL) begin
         src_a = SW'(cmd_idx) - SW'(ws);
         src_b = src_a - SW'(1);
         ok_a  = SW'(cmd_idx) >= SW'(ws);
         ok_b  = SW'(cmd_idx) >= (SW'(ws) + SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
      if (cmd.issue) begin
         if (ok_a) rd_a_ff <= mem[src_a[AW-1:0]];
         if (ok_b) rd_b_ff <= mem[src_b[AW-1:0]];
         a_ok_ff   <= ok_a;
         b_ok_ff   <= ok_b;
         s1_idx_ff <= cmd_idx;
      end
   end

   always_comb begin
      a      = a_ok_ff ? rd_a_ff : 64'd0;
      b      = b_ok_ff ? rd_b_ff : 64'd0;
      m      = word_mask(s1_idx_ff, n_x);
      bitm   = 64'd1 << pos_ff[5:0];
      wdata  = 64'd0;
      wr_en  = 1'b0;
      unique case (cmd.mode)
         MODE_CLEAR: begin
            wr_en = 1'b1;
         end
         MODE_TRIM: begin
            wr_en = 1'b1;
            wdata = a & m;
         end
         MODE_ITEM: begin
            wr_en = 1'b1;
            unique case (kind_e)
               K_SET:      wdata = a | bitm;
               K_CLEAR:    wdata = a & ~bitm;
               K_FLIP:     wdata = a ^ bitm;
               K_SETALL:   wdata = m;
               K_CLEARALL: wdata = 64'd0;
               K_INVERT:   wdata = ~a & m;
               // a zero bit offset shifts the neighbor word fully out
               K_SHL: wdata = ((a << bs) | (b >> (7'd64 - {1'b0, bs}))) & m;
               K_SHR: wdata = ((a >> bs) | (b << (7'd64 - {1'b0, bs}))) & m;
               default:    wr_en = 1'b0;
            endcase
         end
         default: wr_en = 1'b0;
      endcase
      wr_en = wr_en && s1_valid_ff;

      if (s1_idx_ff < stat_word) w_next = 64'd0;
      else if (s1_idx_ff == stat_word) w_next = a & (~64'd0 << off);
      else w_next = a;
      if (s1_idx_ff > stat_word) w_prev = 64'd0;
      else if (s1_idx_ff == stat_word) w_prev = a & (~64'd0 >> (6'd63 - off));
      else w_prev = a;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[s1_idx_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= CNT_W'(CAPACITY_DEF);
      end else if (csr_we) begin
         bit_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= item_kind;
         pos_ff   <= item_position;
         amt_ff   <= item_amount;
         pop_ff   <= '0;
         any_ff   <= 1'b0;
         hit_ff   <= 1'b0;
         bitv_ff  <= 1'b0;
         found_ff <= '0;
      end else if (s1_valid_ff && cmd.mode == MODE_ITEM) begin
         if (kind_e == K_COUNT) pop_ff <= pop_ff + LW'(pop64(a));
         if (kind_e == K_ANY && a != 64'd0) any_ff <= 1'b1;
         if (kind_e == K_TEST) bitv_ff <= |(a & bitm);
         // first hit wins going up, last hit wins for the backward search
         if (is_next && w_next != 64'd0 && !hit_ff) begin
            hit_ff   <= 1'b1;
            found_ff <= {s1_idx_ff, low_index(w_next)};
         end
         if (is_prev && w_prev != 64'd0) begin
            hit_ff   <= 1'b1;
            found_ff <= {s1_idx_ff, high_index(w_prev)};
         end
      end
   end

   always_comb begin
      if (!is_search) found_res = '0;
      else if (is_prev && n_x == XW'(0)) found_res = '0;
      else if (is_next && out_rng) found_res = n_x;
      else if (hit_ff) found_res = XW'(found_ff);
      else found_res = n_x;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         bit_value_ff <= (kind_e == K_TEST) && !out_rng && bitv_ff;
         found_out_ff <= POS_W'(found_res);
         pop_out_ff   <= POS_W'(pop_ff);
         any_out_ff   <= any_ff;
         err_out_ff   <= is_single && out_rng;
      end
   end

   assign out_bit_value   = bit_value_ff;
   assign out_found_index = found_out_ff;
   assign out_population  = pop_out_ff;
   assign out_any_set     = any_out_ff;
   assign out_error       = err_out_ff;

endmodule

[hdl/bve_ctrl.sv]
// Command sequencer: decode, word sweep, drain and result handoff.
module bve_ctrl #(
   parameter int CAPACITY = bve_pkg::CAPACITY_DEF,
   parameter int AW       = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  bve_pkg::dp_stat_type stat,
   input  logic [AW-1:0]        stat_word,
   output bve_pkg::ctl_cmd_type cmd,
   output logic [AW-1:0]        cmd_idx
);
   import bve_pkg::*;

   localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PASS,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type     state_ff;
   mode_type      mode_ff;
   logic [AW-1:0] idx_ff;
   logic          single_ff, desc_ff, out_valid_ff;
   logic          accept, last;

   always_comb begin
      req_tready = (state_ff == S_IDLE) && !csr_we && (!out_valid_ff || rsp_tready);
      accept     = req_tvalid && req_tready;
      if (single_ff) last = 1'b1;
      else if (desc_ff) last = idx_ff == '0;
      else last = idx_ff == AW'(NWORDS - 1);
      cmd.load   = accept;
      cmd.issue  = state_ff == S_PASS;
      cmd.finish = state_ff == S_DONE;
      cmd.mode   = mode_ff;
      cmd_idx    = idx_ff;
      rsp_tvalid = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PASS;        // clearing sweep after reset
         mode_ff      <= MODE_CLEAR;
         idx_ff       <= '0;
         single_ff    <= 1'b0;
         desc_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_we) begin
                  mode_ff   <= MODE_TRIM;
                  idx_ff    <= '0;
                  single_ff <= 1'b0;
                  desc_ff   <= 1'b0;
                  state_ff  <= S_PASS;
               end else if (accept) begin
                  mode_ff  <= MODE_ITEM;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (stat.direct) begin
                  state_ff <= S_DONE;
               end else begin
                  single_ff <= stat.single;
                  desc_ff   <= stat.desc;
                  if (stat.single) idx_ff <= stat_word;
                  else if (stat.desc) idx_ff <= AW'(NWORDS - 1);
                  else idx_ff <= '0;
                  state_ff <= S_PASS;
               end
            end
            S_PASS: begin
               if (last) state_ff <= S_DRAIN;
               else if (desc_ff) idx_ff <= idx_ff - AW'(1);
               else idx_ff <= idx_ff + AW'(1);
            end
            S_DRAIN: begin
               state_ff <= (mode_ff == MODE_ITEM) ? S_DONE : S_IDLE;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DECODE && mode_ff == MODE_ITEM)
      else $error("accepted word did not enter decode");

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> !out_valid_ff)
      else $error("result overwrites an undelivered word");

   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS && last |=> state_ff == S_DRAIN)
      else $error("sweep did not drain after its final word");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("input ready while busy");

endmodule

[hdl/bit_vector_engine_top.sv]
// Top level of the bit vector engine: stream ports, sequencer and datapath.
// Commands that touch no stored word (range errors, unknown kinds, out-of-range searches)
// go from decode straight to the result; single-bit commands sweep their one word, and
// whole-vector commands, searches and shifts sweep every word, one word per cycle.
// Throughput: one word in flight; the next can be accepted in the cycle rsp_tvalid rises at best.
// Reset: synchronous; bit_count returns to 4096 and a clearing sweep over every word
// runs with req_tready low; a bit_count write while idle starts a trim sweep of the same length.
module bit_vector_engine_top #(
   parameter int CAPACITY = bve_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [bve_pkg::REQ_W-1:0] req_tdata,  // position[12:0], amount[25:13]
   input  logic [bve_pkg::KIND_W-1:0] req_tuser, // kind[3:0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // bit_value[0], found_index[13:1], population[26:14], any_set[27], error[28]
   output logic [bve_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [bve_pkg::CNT_W-1:0] csr_wdata
);
   import bve_pkg::*;

   localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic [AW-1:0] cmd_idx, stat_word;
   logic          o_bit, o_any, o_err;
   logic [POS_W-1:0] o_found, o_pop;

   bve_ctrl #(.CAPACITY(CAPACITY), .AW(AW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .stat       (stat),
      .stat_word  (stat_word),
      .cmd        (cmd),
      .cmd_idx    (cmd_idx)
   );

   bve_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .item_kind       (req_tuser),
      .item_position   (req_tdata[12:0]),
      .item_amount     (req_tdata[25:13]),
      .cmd             (cmd),
      .cmd_idx         (cmd_idx),
      .stat            (stat),
      .stat_word       (stat_word),
      .out_bit_value   (o_bit),
      .out_found_index (o_found),
      .out_population  (o_pop),
      .out_any_set     (o_any),
      .out_error       (o_err)
   );

   assign rsp_tdata = {3'b000, o_err, o_any, o_pop, o_found, o_bit};

endmodule
